FILE: rtl/core/ttd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared types, codes, message ROM and segment table of the terminal type detector.
// ----------------------------------------------------------------------------
package ttd_pkg;

   localparam int MSG_LEN = 91;

   // input commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_SETTLE = 3'd0;
   localparam logic [2:0] REG_PROBE  = 3'd1;
   localparam logic [2:0] REG_DOT    = 3'd2;
   localparam logic [2:0] REG_SECOND = 3'd3;
   localparam logic [2:0] REG_PROMPT = 3'd4;
   localparam logic [2:0] REG_TRIES  = 3'd5;

   // result status
   localparam logic [1:0] ST_PENDING = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // terminal types
   localparam logic [2:0] TT_UNKNOWN = 3'd0;
   localparam logic [2:0] TT_ANSI    = 3'd1;
   localparam logic [2:0] TT_ASCII   = 3'd2;
   localparam logic [2:0] TT_PET40   = 3'd3;
   localparam logic [2:0] TT_PET80   = 3'd4;

   // character sets
   localparam logic [1:0] CS_CP437   = 2'd0;
   localparam logic [1:0] CS_UTF8    = 2'd1;
   localparam logic [1:0] CS_ASCII   = 2'd2;
   localparam logic [1:0] CS_PETSCII = 2'd3;

   typedef logic [2:0] seg_type;
   localparam seg_type SEG_NONE   = 3'd0;
   localparam seg_type SEG_PROBE  = 3'd1;
   localparam seg_type SEG_CLRKEY = 3'd2;
   localparam seg_type SEG_KEY    = 3'd3;
   localparam seg_type SEG_COLS   = 3'd4;
   localparam seg_type SEG_CRLF   = 3'd5;
   localparam seg_type SEG_ANSI   = 3'd6;
   localparam seg_type SEG_CR     = 3'd7;

   localparam logic [6:0] DOT_BASE = 7'd0;

   // all outgoing text, one segment after another
   localparam logic [0:MSG_LEN-1][7:0] MSG_ROM = {
      ".",
      8'h0D, 8'h0A, 8'h0D, 8'h0A, "DETECTING TERMINAL",
      8'h1B, "[6n", 8'hE2, 8'h94, 8'h80, 8'h1B, "[6n",
      8'h93,
      8'h0D, 8'h0A, "HIT DEL OR BACKSPACE: ",
      8'h0D, "40 OR 80 COLUMNS (4/8)? ",
      8'h0D, 8'h0A,
      8'h0D, 8'h1B, "[K",
      8'h0D
   };

   typedef struct packed {
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       dot;
      seg_type    seg;
      logic [1:0] status;
      logic [2:0] term_type;
      logic [1:0] char_set;
      logic [6:0] screen_cols;
      logic [4:0] screen_rows;
   } dp_stat_type;

   function automatic logic [6:0] seg_base(input seg_type s);
      logic [6:0] r;
      unique case (s)
         SEG_PROBE:  r = 7'd1;
         SEG_CLRKEY: r = 7'd34;
         SEG_KEY:    r = 7'd35;
         SEG_COLS:   r = 7'd59;
         SEG_CRLF:   r = 7'd84;
         SEG_ANSI:   r = 7'd86;
         SEG_CR:     r = 7'd90;
         default:    r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] seg_len(input seg_type s);
      logic [5:0] r;
      unique case (s)
         SEG_PROBE:  r = 6'd33;
         SEG_CLRKEY: r = 6'd25;
         SEG_KEY:    r = 6'd24;
         SEG_COLS:   r = 6'd25;
         SEG_CRLF:   r = 6'd2;
         SEG_ANSI:   r = 6'd4;
         SEG_CR:     r = 6'd1;
         default:    r = 6'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ttd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_datapath
// Detection state, reply parser, timers and configuration registers.
// ----------------------------------------------------------------------------
module ttd_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ttd_pkg::ctrl_cmd_type cmd,
   input  wire logic [1:0]           command,
   input  wire logic [7:0]           data_byte,
   input  wire logic [31:0]          now,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [19:0]          csr_data,
   output ttd_pkg::dp_stat_type      stat
);
   localparam logic [2:0] PH_IDLE = 3'd0, PH_SETTLE = 3'd1, PH_PROBE = 3'd2,
                          PH_ASKKEY = 3'd3, PH_ASKCOLS = 3'd4, PH_DONE = 3'd5;

   logic [15:0] settle_ff, pto_ff, dint_ff, srw_ff;
   logic [19:0] prompt_ff;
   logic [3:0]  tries_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  rps_ff, rps_in;
   logic        nidx_ff, nidx_in;
   logic [13:0] num0_ff, num0_in, num1_ff, num1_in, col0_ff, col0_in, col1_ff, col1_in;
   logic [1:0]  rcnt_ff, rcnt_in;
   logic [3:0]  dots_ff, dots_in, wrong_ff, wrong_in;
   logic [31:0] dl_ff, dl_in, nd_ff, nd_in;
   logic [2:0]  ftype_ff, ftype_in;
   logic [1:0]  fcs_ff, fcs_in;
   logic [6:0]  fcols_ff, fcols_in;
   logic [4:0]  frows_ff, frows_in;
   logic [1:0]  status_ff, status_in;
   logic        dot_ff, dot_in;
   ttd_pkg::seg_type seg_ff, seg_in;

   // parser results
   logic [1:0]  p_rps;
   logic        p_nidx, p_hit, p_done;
   logic [13:0] p_num0, p_num1, p_col0, p_col1, p_sel, p_grow;
   logic [1:0]  p_rcnt;
   logic [3:0]  wrong_inc;
   logic        dl_hit, nd_hit;
   logic [31:0] dl_diff, nd_diff;

   assign dl_diff = now - dl_ff;
   assign nd_diff = now - nd_ff;
   assign dl_hit  = ~dl_diff[31];
   assign nd_hit  = ~nd_diff[31];
   assign p_sel   = nidx_ff ? num1_ff : num0_ff;
   assign p_grow  = p_sel * 14'd10 + {10'd0, data_byte[3:0]};
   assign wrong_inc = (wrong_ff == 4'd15) ? wrong_ff : wrong_ff + 4'd1;

   always_comb begin
      p_rps = rps_ff; p_nidx = nidx_ff; p_num0 = num0_ff; p_num1 = num1_ff;
      p_col0 = col0_ff; p_col1 = col1_ff; p_rcnt = rcnt_ff;
      p_hit = 1'b0; p_done = 1'b0;
      case (rps_ff)
         2'd0: begin
            if (data_byte == 8'h1B) begin
               p_rps = 2'd1; p_hit = 1'b1;
            end
         end
         2'd1: begin
            if (data_byte == "[") begin
               p_rps = 2'd2; p_nidx = 1'b0; p_num0 = '0; p_num1 = '0; p_hit = 1'b1;
            end else begin
               p_rps = 2'd0;
            end
         end
         2'd2: begin
            p_hit = 1'b1;
            if (data_byte >= "0" && data_byte <= "9") begin
               if (p_sel < 14'd1000) begin
                  if (nidx_ff) p_num1 = p_grow;
                  else         p_num0 = p_grow;
               end
            end else if (data_byte == ";") begin
               p_nidx = 1'b1;
            end else begin
               p_rps = 2'd0;
               if (data_byte == "R") begin
                  if (rcnt_ff == 2'd0) p_col0 = num1_ff;
                  if (rcnt_ff == 2'd1) p_col1 = num1_ff;
                  if (rcnt_ff != 2'd3) p_rcnt = rcnt_ff + 2'd1;
                  p_done = 1'b1;
               end
            end
         end
         default: p_rps = 2'd0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff; rps_in = rps_ff; nidx_in = nidx_ff;
      num0_in = num0_ff; num1_in = num1_ff; col0_in = col0_ff; col1_in = col1_ff;
      rcnt_in = rcnt_ff; dots_in = dots_ff; wrong_in = wrong_ff;
      dl_in = dl_ff; nd_in = nd_ff;
      ftype_in = ftype_ff; fcs_in = fcs_ff; fcols_in = fcols_ff; frows_in = frows_ff;
      status_in = ttd_pkg::ST_PENDING; dot_in = 1'b0; seg_in = ttd_pkg::SEG_NONE;
      case (command)
         ttd_pkg::CMD_START: begin
            phase_in = PH_SETTLE; rps_in = 2'd0; nidx_in = 1'b0; rcnt_in = 2'd0;
            dots_in = 4'd0; wrong_in = 4'd0; ftype_in = ttd_pkg::TT_UNKNOWN;
            dl_in = now + {16'd0, settle_ff};
         end
         ttd_pkg::CMD_BYTE: begin
            case (phase_ff)
               PH_SETTLE: ;
               PH_PROBE, PH_ASKKEY: begin
                  rps_in = p_rps; nidx_in = p_nidx; num0_in = p_num0; num1_in = p_num1;
                  col0_in = p_col0; col1_in = p_col1; rcnt_in = p_rcnt;
                  if (p_hit && p_done && (phase_ff == PH_ASKKEY || p_rcnt >= 2'd2)) begin
                     seg_in = ttd_pkg::SEG_ANSI; status_in = ttd_pkg::ST_DONE;
                     phase_in = PH_DONE;
                     ftype_in = ttd_pkg::TT_ANSI; fcols_in = 7'd80; frows_in = 5'd24;
                     fcs_in = (p_rcnt >= 2'd2 && {1'b0, p_col1} == {1'b0, p_col0} + 15'd1)
                              ? ttd_pkg::CS_UTF8 : ttd_pkg::CS_CP437;
                  end else if (p_hit && p_done) begin
                     dl_in = now + {16'd0, srw_ff};
                  end else if (p_hit || phase_ff == PH_PROBE) begin
                     // reply byte in progress, or any other byte while probing: nothing else to do
                  end else if (data_byte == 8'h14) begin
                     seg_in = ttd_pkg::SEG_COLS; phase_in = PH_ASKCOLS;
                     dl_in = now + {12'd0, prompt_ff};
                  end else if (data_byte == 8'h08 || data_byte == 8'h7F) begin
                     seg_in = ttd_pkg::SEG_CRLF; status_in = ttd_pkg::ST_DONE;
                     phase_in = PH_DONE;
                     ftype_in = ttd_pkg::TT_ASCII; fcs_in = ttd_pkg::CS_ASCII;
                     fcols_in = 7'd80; frows_in = 5'd24;
                  end else if (data_byte == 8'h0A || data_byte == 8'h00) begin
                     // ignore line feed and null
                  end else begin
                     wrong_in = wrong_inc;
                     if (wrong_inc >= tries_ff) begin
                        seg_in = ttd_pkg::SEG_CRLF; status_in = ttd_pkg::ST_DONE;
                        phase_in = PH_DONE;
                        ftype_in = ttd_pkg::TT_ASCII; fcs_in = ttd_pkg::CS_ASCII;
                        fcols_in = 7'd80; frows_in = 5'd24;
                     end else begin
                        seg_in = ttd_pkg::SEG_KEY; dl_in = now + {12'd0, prompt_ff};
                     end
                  end
               end
               PH_ASKCOLS: begin
                  if (data_byte == "4" || data_byte == 8'h0D) begin
                     seg_in = ttd_pkg::SEG_CR; status_in = ttd_pkg::ST_DONE;
                     phase_in = PH_DONE;
                     ftype_in = ttd_pkg::TT_PET40; fcs_in = ttd_pkg::CS_PETSCII;
                     fcols_in = 7'd40; frows_in = 5'd25;
                  end else if (data_byte == "8") begin
                     seg_in = ttd_pkg::SEG_CR; status_in = ttd_pkg::ST_DONE;
                     phase_in = PH_DONE;
                     ftype_in = ttd_pkg::TT_PET80; fcs_in = ttd_pkg::CS_PETSCII;
                     fcols_in = 7'd80; frows_in = 5'd25;
                  end else begin
                     seg_in = ttd_pkg::SEG_COLS; dl_in = now + {12'd0, prompt_ff};
                  end
               end
               default: status_in = ttd_pkg::ST_DONE;
            endcase
         end
         ttd_pkg::CMD_TICK: begin
            case (phase_ff)
               PH_SETTLE: begin
                  if (dl_hit) begin
                     phase_in = PH_PROBE; seg_in = ttd_pkg::SEG_PROBE;
                     dl_in = now + {16'd0, pto_ff};
                     nd_in = now + {16'd0, dint_ff};
                  end
               end
               PH_PROBE: begin
                  if (rcnt_ff == 2'd0 && dots_ff < 4'd8 && nd_hit) begin
                     dot_in = 1'b1; dots_in = dots_ff + 4'd1;
                     nd_in = nd_ff + {16'd0, dint_ff};
                  end
                  if (dl_hit) begin
                     if (rcnt_ff != 2'd0) begin
                        seg_in = ttd_pkg::SEG_ANSI; status_in = ttd_pkg::ST_DONE;
                        phase_in = PH_DONE;
                        ftype_in = ttd_pkg::TT_ANSI; fcols_in = 7'd80; frows_in = 5'd24;
                        fcs_in = (rcnt_ff >= 2'd2 && {1'b0, col1_ff} == {1'b0, col0_ff} + 15'd1)
                                 ? ttd_pkg::CS_UTF8 : ttd_pkg::CS_CP437;
                     end else begin
                        seg_in = ttd_pkg::SEG_CLRKEY; phase_in = PH_ASKKEY;
                        dl_in = now + {12'd0, prompt_ff};
                     end
                  end
               end
               PH_ASKKEY, PH_ASKCOLS:
                  status_in = dl_hit ? ttd_pkg::ST_TIMEOUT : ttd_pkg::ST_PENDING;
               default: status_in = ttd_pkg::ST_DONE;
            endcase
         end
         default: status_in = (phase_ff == PH_IDLE || phase_ff == PH_DONE)
                              ? ttd_pkg::ST_DONE : ttd_pkg::ST_PENDING;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= 16'd500; pto_ff <= 16'd3000; dint_ff <= 16'd250;
         srw_ff <= 16'd500; prompt_ff <= 20'd30000; tries_ff <= 4'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            ttd_pkg::REG_SETTLE: settle_ff <= csr_data[15:0];
            ttd_pkg::REG_PROBE:  pto_ff    <= csr_data[15:0];
            ttd_pkg::REG_DOT:    dint_ff   <= csr_data[15:0];
            ttd_pkg::REG_SECOND: srw_ff    <= csr_data[15:0];
            ttd_pkg::REG_PROMPT: prompt_ff <= csr_data;
            ttd_pkg::REG_TRIES:  tries_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; rps_ff <= 2'd0; nidx_ff <= 1'b0;
         num0_ff <= '0; num1_ff <= '0; col0_ff <= '0; col1_ff <= '0;
         rcnt_ff <= 2'd0; dots_ff <= 4'd0; wrong_ff <= 4'd0;
         dl_ff <= '0; nd_ff <= '0;
         ftype_ff <= ttd_pkg::TT_UNKNOWN; fcs_ff <= ttd_pkg::CS_CP437;
         fcols_ff <= 7'd0; frows_ff <= 5'd0;
         status_ff <= ttd_pkg::ST_PENDING; dot_ff <= 1'b0; seg_ff <= ttd_pkg::SEG_NONE;
      end else if (cmd.exec) begin
         phase_ff <= phase_in; rps_ff <= rps_in; nidx_ff <= nidx_in;
         num0_ff <= num0_in; num1_ff <= num1_in; col0_ff <= col0_in; col1_ff <= col1_in;
         rcnt_ff <= rcnt_in; dots_ff <= dots_in; wrong_ff <= wrong_in;
         dl_ff <= dl_in; nd_ff <= nd_in;
         ftype_ff <= ftype_in; fcs_ff <= fcs_in; fcols_ff <= fcols_in; frows_ff <= frows_in;
         status_ff <= status_in; dot_ff <= dot_in; seg_ff <= seg_in;
      end
   end

   assign stat.dot         = dot_ff;
   assign stat.seg         = seg_ff;
   assign stat.status      = status_ff;
   assign stat.term_type   = ftype_ff;
   assign stat.char_set    = fcs_ff;
   assign stat.screen_cols = fcols_ff;
   assign stat.screen_rows = frows_ff;

endmodule
`default_nettype wire

FILE: rtl/core/ttd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttd_ctrl
// Item sequencer: takes a request, runs the datapath, streams out the beats.
// ----------------------------------------------------------------------------
module ttd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output ttd_pkg::ctrl_cmd_type    cmd,
   input  wire ttd_pkg::dp_stat_type stat,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_has_byte,
   output logic [1:0]               rsp_status,
   output logic [2:0]               rsp_term_type,
   output logic [1:0]               rsp_char_set,
   output logic [6:0]               rsp_screen_cols,
   output logic [4:0]               rsp_screen_rows,
   output logic                     rsp_last
);
   localparam logic [1:0] S_IDLE = 2'd0, S_PLAN = 2'd1, S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [6:0] ptr_ff, ptr_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       more_ff, more_in, empty_ff, empty_in;
   logic       vld_ff, vld_in, out_free, load, beat_last;
   logic [7:0] byte_ff;
   logic       has_ff, last_ff;
   ttd_pkg::dp_stat_type st_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign cmd.exec  = req_valid && !req_stall;
   assign out_free  = !vld_ff || !rsp_stall;
   assign load      = (state_ff == S_EMIT) && out_free;
   assign beat_last = empty_ff || (cnt_ff == 6'd1 && !more_ff);

   always_comb begin
      state_in = state_ff; ptr_in = ptr_ff; cnt_in = cnt_ff;
      more_in = more_ff; empty_in = empty_ff;
      vld_in = load ? 1'b1 : (vld_ff && rsp_stall);
      unique case (state_ff)
         S_IDLE: if (cmd.exec) state_in = S_PLAN;
         S_PLAN: begin
            state_in = S_EMIT;
            empty_in = 1'b0;
            if (stat.dot) begin
               ptr_in = ttd_pkg::DOT_BASE; cnt_in = 6'd1;
               more_in = (stat.seg != ttd_pkg::SEG_NONE);
            end else if (stat.seg != ttd_pkg::SEG_NONE) begin
               ptr_in = ttd_pkg::seg_base(stat.seg); cnt_in = ttd_pkg::seg_len(stat.seg);
               more_in = 1'b0;
            end else begin
               empty_in = 1'b1; more_in = 1'b0; cnt_in = 6'd1;
            end
         end
         S_EMIT: begin
            if (load) begin
               if (beat_last) begin
                  state_in = S_IDLE;
               end else if (cnt_ff == 6'd1) begin
                  // dot done, advance to the main segment
                  ptr_in = ttd_pkg::seg_base(stat.seg); cnt_in = ttd_pkg::seg_len(stat.seg);
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 7'd1; cnt_in = cnt_ff - 6'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0; more_ff <= 1'b0; empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in; more_ff <= more_in; empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      if (load) begin
         byte_ff <= empty_ff ? 8'd0 : ttd_pkg::MSG_ROM[ptr_ff];
         has_ff  <= !empty_ff;
         last_ff <= beat_last;
         st_ff   <= stat;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_has_byte    = has_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = st_ff.status;
   assign rsp_term_type   = st_ff.term_type;
   assign rsp_char_set    = st_ff.char_set;
   assign rsp_screen_cols = st_ff.screen_cols;
   assign rsp_screen_rows = st_ff.screen_rows;

endmodule
`default_nettype wire

FILE: rtl/core/terminal_type_detector_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_type_detector_unit
// Serial terminal type detector: probe, reply parsing and key prompts.
// ----------------------------------------------------------------------------
// An item is accepted and the detection state updated at the same edge, the
// next cycle plans its output, then the result beats follow, 1 to 33 of them
// (the probe being the longest), from the sequencer that reads the message
// ROM one byte a cycle while the result side does not stall. A finished beat
// waits in the output register while the next item is taken.
module terminal_type_detector_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_term_type,
   output logic [1:0]       rsp_char_set,
   output logic [6:0]       rsp_screen_cols,
   output logic [4:0]       rsp_screen_rows,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);
   ttd_pkg::ctrl_cmd_type cmd;
   ttd_pkg::dp_stat_type  stat;

   ttd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .command(req_command), .data_byte(req_data_byte), .now(req_now),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .stat(stat)
   );

   ttd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .cmd(cmd), .stat(stat), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_status(rsp_status), .rsp_term_type(rsp_term_type),
      .rsp_char_set(rsp_char_set), .rsp_screen_cols(rsp_screen_cols),
      .rsp_screen_rows(rsp_screen_rows), .rsp_last(rsp_last)
   );

`ifndef ASSERT_OFF
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_last)
      else $error("empty beat without last");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status code");
`endif

endmodule
`default_nettype wire
